@@ rtl/longest_remaining_time_scheduler_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the longest-remaining-time scheduler core.
// Each macro expects clk and rst_n in scope; checks are off during reset.
// ----------------------------------------------------------------------------
`ifndef LONGEST_REMAINING_TIME_SCHEDULER_CORE_ASSERT_SVH
`define LONGEST_REMAINING_TIME_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication
`define LRTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LRTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lrts_pkg.sv @@
// ----------------------------------------------------------------------------
// lrts_pkg
// Shared constants, types and codes of the longest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package lrts_pkg;

  // Sizing
  localparam int NUM_SLOTS = 4;
  localparam int TIME_BITS = 16;
  localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Field widths of the stream items
  localparam int CMD_W      = 2;
  localparam int IN_SLOT_W  = 2;
  localparam int FIELD_W    = 16;
  localparam int OUT_SLOT_W = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;

  // Command codes; code 3 is unused and behaves as a no-op
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef logic [TIME_BITS-1:0]                time_t;
  typedef logic [NUM_SLOTS-1:0][TIME_BITS-1:0] time_vec_t;
  typedef logic [SLOT_BITS-1:0]                slot_t;

  // Result of the slot selection
  typedef struct packed {
    logic  valid;
    slot_t slot;
    time_t rem;
  } pick_t;

endpackage

@@ rtl/lrts_pick.sv @@
// ----------------------------------------------------------------------------
// lrts_pick
// Chooses the arrived slot with the largest nonzero remaining burst;
// ties go to the lowest slot.
// ----------------------------------------------------------------------------
module lrts_pick (
  input  lrts_pkg::time_vec_t arrival,
  input  lrts_pkg::time_vec_t remaining,
  input  lrts_pkg::time_t     now,
  output lrts_pkg::pick_t     pick
);

  // Compare chain over the slots, strict greater keeps the lower slot on ties
  always_comb begin
    logic elig;
    pick = '0;
    for (int i = 0; i < lrts_pkg::NUM_SLOTS; i++) begin
      elig = (arrival[i] <= now) && (remaining[i] != '0);
      if (elig && (!pick.valid || (remaining[i] > pick.rem))) begin
        pick.valid = 1'b1;
        pick.slot  = lrts_pkg::SLOT_BITS'(i);
        pick.rem   = remaining[i];
      end
    end
  end

endmodule

@@ rtl/longest_remaining_time_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// longest_remaining_time_scheduler_core
// Preemptive longest-remaining-time-first scheduler over a small set of
// process slots, driven by a command stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one command per transfer. in_tuser carries the
//   command (load slot, advance one tick, clear all); in_tdata carries the
//   slot, arrival and burst used by a load.
//   Output stream (out_*): exactly one result per command: whether a slot
//   ran, which one, completion/turnaround/waiting on completion, and the
//   clock after the command.
//   Order: a command is taken into the input register, processed from there
//   when the result register is free or being read, and its result is
//   registered in the result register, from which it is presented.
//   Throughput: one command per cycle when not stalled; the path is the slot
//   compare chain, a decrement and the turnaround/waiting subtracts.
//   Stalls: the input register and the result register form a two-deep
//   pipe; while out_tready is low a held result blocks the input register
//   and in_tready drops once both are full. Nothing is lost or repeated.
//   Reset: synchronous active-low rst_n empties the pipe, clears all slots
//   and sets the clock to zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module longest_remaining_time_scheduler_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // Command input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [1:0] slot, [17:2] arrival, [33:18] burst, [39:34] zero
  input  logic [lrts_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] command
  input  logic [lrts_pkg::CMD_W-1:0]        in_tuser,
  // Result output
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] ran, [2:1] running_slot, [3] completed, [19:4] completion_time,
  // [35:20] turnaround, [51:36] waiting, [67:52] time_now, [71:68] zero
  output logic [lrts_pkg::OUT_DATA_W-1:0]   out_tdata
);

  `include "longest_remaining_time_scheduler_core_assert.svh"

  localparam int FW = lrts_pkg::FIELD_W;

  // Input register
  logic                             in_valid_r, in_valid_nxt;
  logic [lrts_pkg::CMD_W-1:0]       cmd_r;
  logic [lrts_pkg::IN_SLOT_W-1:0]   slot_r;
  logic [FW-1:0]                    arrival_r;
  logic [FW-1:0]                    burst_r;

  // Scheduler state
  lrts_pkg::time_vec_t arr_r, arr_nxt;
  lrts_pkg::time_vec_t rem_r, rem_nxt;
  lrts_pkg::time_vec_t orig_r, orig_nxt;
  lrts_pkg::time_t     time_r, time_nxt;

  // Result register
  logic                                  out_valid_r, out_valid_nxt;
  logic [lrts_pkg::OUT_DATA_W-1:0]       out_data_r, out_data_nxt;

  logic            adv;
  lrts_pkg::pick_t pick;
  lrts_pkg::time_t tick_time, turn, wait_time, load_arr, load_bur;
  logic            ran, done;

  // Pipe control: the input register moves on when the result slot frees up
  assign adv           = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready     = !in_valid_r || adv;
  assign in_valid_nxt  = (in_tvalid && in_tready) ? 1'b1 : (adv ? 1'b0 : in_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

  lrts_pick u_pick (
    .arrival   (arr_r),
    .remaining (rem_r),
    .now       (time_r),
    .pick      (pick)
  );

  // Tick arithmetic on the selected slot
  assign load_arr  = lrts_pkg::TIME_BITS'(arrival_r);
  assign load_bur  = lrts_pkg::TIME_BITS'(burst_r);
  assign tick_time = (time_r != '1) ? time_r + 1'b1 : time_r;
  assign turn      = tick_time - arr_r[pick.slot];
  assign wait_time = (turn >= orig_r[pick.slot]) ? turn - orig_r[pick.slot] : '0;

  // Command execution and result packing
  always_comb begin
    arr_nxt      = arr_r;
    rem_nxt      = rem_r;
    orig_nxt     = orig_r;
    time_nxt     = time_r;
    ran          = 1'b0;
    done         = 1'b0;
    out_data_nxt = '0;
    if (adv) begin
      unique case (cmd_r)
        lrts_pkg::CMD_LOAD: begin
          for (int i = 0; i < lrts_pkg::NUM_SLOTS; i++) begin
            if (int'(slot_r) == i) begin
              arr_nxt[i]  = load_arr;
              rem_nxt[i]  = load_bur;
              orig_nxt[i] = load_bur;
            end
          end
        end
        lrts_pkg::CMD_TICK: begin
          time_nxt = tick_time;
          if (pick.valid) begin
            ran                 = 1'b1;
            rem_nxt[pick.slot]  = pick.rem - 1'b1;
            done                = (pick.rem == lrts_pkg::TIME_BITS'(1));
          end
        end
        lrts_pkg::CMD_CLEAR: begin
          arr_nxt  = '0;
          rem_nxt  = '0;
          orig_nxt = '0;
          time_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    out_data_nxt[0]     = ran;
    out_data_nxt[2:1]   = ran ? lrts_pkg::OUT_SLOT_W'(pick.slot) : '0;
    out_data_nxt[3]     = done;
    out_data_nxt[19:4]  = done ? FW'(tick_time) : '0;
    out_data_nxt[35:20] = done ? FW'(turn) : '0;
    out_data_nxt[51:36] = done ? FW'(wait_time) : '0;
    out_data_nxt[67:52] = FW'(time_nxt);
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      arr_r       <= '0;
      rem_r       <= '0;
      orig_r      <= '0;
      time_r      <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      arr_r       <= arr_nxt;
      rem_r       <= rem_nxt;
      orig_r      <= orig_nxt;
      time_r      <= time_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r     <= in_tuser;
      slot_r    <= in_tdata[1:0];
      arrival_r <= in_tdata[17:2];
      burst_r   <= in_tdata[33:18];
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  `LRTS_ASSERT_IMP(a_ready_blocked, !in_tready, in_valid_r && out_valid_r && !out_tready,
    "input stalled without a full pipe")
  `LRTS_ASSERT_IMP(a_done_has_run, out_valid_r && out_data_r[3], out_data_r[0],
    "completion reported without a served slot")
  `LRTS_ASSERT_NXT(a_tick_clock, adv && (cmd_r == lrts_pkg::CMD_TICK) && (time_r != '1),
    time_r == $past(time_r) + 1'b1, "clock did not advance on a tick")
  `LRTS_ASSERT_NXT(a_clear_all, adv && (cmd_r == lrts_pkg::CMD_CLEAR),
    (time_r == '0) && (rem_r == '0), "clear left state behind")

endmodule
